// File: design/etd_pkg.sv
// Package for the epoch-seconds-to-date converter: constants, types and the month-length table.
package etd_pkg;

  // Calendar origin and fixed time constants.
  localparam int BASE_YEAR     = 1970;
  localparam int SECS_PER_DAY  = 24 * 60 * 60;
  localparam int SECS_PER_HOUR = 60 * 60;
  localparam int SECS_PER_MIN  = 60;

  // Field widths of the result.
  localparam int YEAR_W   = 12;
  localparam int REM_W    = 25;
  localparam int DOY_W    = 9;

  // Seconds in a common and in a leap year.
  localparam logic [31:0] SECS_COMMON = 32'(365 * SECS_PER_DAY);
  localparam logic [31:0] SECS_LEAP   = 32'(366 * SECS_PER_DAY);

  // Starting year and its residues for the leap test.
  localparam logic [YEAR_W-1:0] YEAR_INIT = YEAR_W'(BASE_YEAR);
  localparam logic [1:0]        MOD4_INIT   = 2'(BASE_YEAR % 4);
  localparam logic [6:0]        MOD100_INIT = 7'(BASE_YEAR % 100);
  localparam logic [8:0]        MOD400_INIT = 9'(BASE_YEAR % 400);

  // Reciprocals for the day, hour and minute splits. The power-of-two factor of each
  // divisor is shifted out first, which leaves 675, 225 and 15; each reciprocal is
  // rounded up and exact over the operand range (18, 13 and 10 bits).
  localparam logic [18:0] DAY_RECIP  = 19'd397683;  // 2^28 / 675, rounded up
  localparam logic [12:0] HOUR_RECIP = 13'd4661;    // 2^20 / 225, rounded up
  localparam logic [10:0] MIN_RECIP  = 11'd1093;    // 2^14 / 15, rounded up

  // Divisors at the widths of the remainder arithmetic.
  localparam logic [REM_W-1:0] DAY_SECS  = REM_W'(SECS_PER_DAY);
  localparam logic [16:0]      HOUR_SECS = 17'(SECS_PER_HOUR);
  localparam logic [11:0]      MIN_SECS  = 12'(SECS_PER_MIN);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic year_step;
    logic div_init;
    logic div_step;
    logic month_step;
    logic out_load;
  } etd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_more;
    logic div_done;
    logic month_more;
    logic out_free;
  } etd_sts_t;

  // Days in a month; zero for codes that are not months.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: design/etd_in_if.sv
// Input channel interface: valid, ready and the seconds count.
interface etd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

// File: design/etd_out_if.sv
// Result channel interface: valid, ready and the calendar fields.
interface etd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_of_month;
  logic [8:0]  day_of_year;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  modport source (output valid, output year_out, output month_out, output day_of_month,
                  output day_of_year, output hour_out, output minute_out,
                  output second_out, input ready);
  modport sink (input valid, input year_out, input month_out, input day_of_month,
                input day_of_year, input hour_out, input minute_out,
                input second_out, output ready);
endinterface

// File: design/etd_ctrl.sv
// Controller state machine that sequences the year walk, divisions and month walk.
module etd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  etd_pkg::etd_sts_t sts,
  output etd_pkg::etd_cmd_t cmd
);
  import etd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_YEAR  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_MONTH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/etd_dp.sv
// Datapath: year subtraction, reciprocal-multiply day and time split, month walk and result register.
module etd_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         epoch_seconds,
  input  etd_pkg::etd_cmd_t   cmd,
  output etd_pkg::etd_sts_t   sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [11:0]         year_out,
  output logic [3:0]          month_out,
  output logic [4:0]          day_of_month,
  output logic [8:0]          day_of_year,
  output logic [4:0]          hour_out,
  output logic [5:0]          minute_out,
  output logic [5:0]          second_out
);
  import etd_pkg::*;

  typedef enum logic [1:0] {
    PH_DAY  = 2'd0,
    PH_HOUR = 2'd1,
    PH_MIN  = 2'd2
  } phase_t;

  // Working registers.
  logic [31:0]       left;
  logic [YEAR_W-1:0] year;
  logic [1:0]        mod4;
  logic [6:0]        mod100;
  logic [8:0]        mod400;
  phase_t            phase;
  logic              rem_cycle;
  logic [DOY_W-1:0]  quot;
  logic [DOY_W-1:0]  doy;
  logic [4:0]        hour;
  logic [5:0]        minute;
  logic [5:0]        second;
  logic [DOY_W-1:0]  day;
  logic [3:0]        month;

  logic              leap;
  logic [31:0]       year_secs;
  logic [36:0]       day_prod;
  logic [24:0]       hour_prod;
  logic [19:0]       min_prod;
  logic [REM_W-1:0]  day_rem;
  logic [16:0]       hour_rem;
  logic [11:0]       min_rem;
  logic [4:0]        mlen;

  // Leap test from the running residues of the year.
  assign leap      = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign year_secs = leap ? SECS_LEAP : SECS_COMMON;

  // Quotients by reciprocal multiplication, after the low zero bits of each divisor are
  // shifted out.
  assign day_prod  = 37'(left[24:7]) * 37'(DAY_RECIP);
  assign hour_prod = 25'(left[16:4]) * 25'(HOUR_RECIP);
  assign min_prod  = 20'(left[11:2]) * 20'(MIN_RECIP);

  // Remainders from the registered quotient.
  assign day_rem  = left[REM_W-1:0] - REM_W'(quot) * DAY_SECS;
  assign hour_rem = left[16:0] - 17'(quot[4:0]) * HOUR_SECS;
  assign min_rem  = left[11:0] - 12'(quot[5:0]) * MIN_SECS;

  assign mlen = month_len(leap, month);

  // Status to the controller.
  always_comb begin
    sts.year_more  = left >= year_secs;
    sts.div_done   = (phase == PH_MIN) && rem_cycle;
    sts.month_more = (day > {4'd0, mlen}) && (month != MONTH_DEC);
    sts.out_free   = !out_valid || out_ready;
  end

  // Year walk, day and time split, and month walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left   <= epoch_seconds;
      year   <= YEAR_INIT;
      mod4   <= MOD4_INIT;
      mod100 <= MOD100_INIT;
      mod400 <= MOD400_INIT;
    end
    if (cmd.year_step) begin
      left   <= left - year_secs;
      year   <= year + YEAR_W'(1);
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
    end
    if (cmd.div_init) begin
      phase     <= PH_DAY;
      rem_cycle <= 1'b0;
    end
    // Each split works out the quotient first, then the remainder.
    if (cmd.div_step) begin
      rem_cycle <= !rem_cycle;
      if (!rem_cycle) begin
        unique case (phase)
          PH_DAY:  quot <= day_prod[36:28];
          PH_HOUR: quot <= {4'd0, hour_prod[24:20]};
          PH_MIN:  quot <= {3'd0, min_prod[19:14]};
          default: quot <= '0;
        endcase
      end else begin
        unique case (phase)
          PH_DAY: begin
            left  <= {7'd0, day_rem};
            doy   <= quot + DOY_W'(1);
            day   <= quot + DOY_W'(1);
            month <= MONTH_JAN;
            phase <= PH_HOUR;
          end
          PH_HOUR: begin
            left  <= {15'd0, hour_rem};
            hour  <= quot[4:0];
            phase <= PH_MIN;
          end
          PH_MIN: begin
            minute <= quot[5:0];
            second <= min_rem[5:0];
          end
          default: begin
            phase <= PH_DAY;
          end
        endcase
      end
    end
    if (cmd.month_step) begin
      day   <= day - {4'd0, mlen};
      month <= month + 4'd1;
    end
  end

  // Result register; valid is the only control bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      year_out     <= year;
      month_out    <= month;
      day_of_month <= day[4:0];
      day_of_year  <= doy;
      hour_out     <= hour;
      minute_out   <= minute;
      second_out   <= second;
    end
  end

endmodule

// File: design/epoch_seconds_to_date.sv
// Each item passes through a year walk over Y, the whole years past the base year (Y tops
// out at 136), the day, hour and minute split, and a month walk over M months (up to 11).
// One item is worked at a time; the next transfer is taken once the result is registered
// and the controller is back in idle, so a stalled result also holds off new input.
// Reset (synchronous, active high) returns the controller to idle and drops result valid.
module epoch_seconds_to_date (
  input logic clk,
  input logic rst,
  etd_in_if.sink    request,
  etd_out_if.source result
);
  import etd_pkg::*;

  etd_cmd_t cmd;
  etd_sts_t sts;

  // Sequencer.
  etd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  etd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .epoch_seconds (request.epoch_seconds),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .year_out      (result.year_out),
    .month_out     (result.month_out),
    .day_of_month  (result.day_of_month),
    .day_of_year   (result.day_of_year),
    .hour_out      (result.hour_out),
    .minute_out    (result.minute_out),
    .second_out    (result.second_out)
  );

endmodule

// File: design/etd_checker.sv
// Port-level checker for the epoch-seconds-to-date converter, with its bind.
module etd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] year_out,
  input logic [3:0]  month_out,
  input logic [4:0]  day_of_month,
  input logic [8:0]  day_of_year,
  input logic [4:0]  hour_out,
  input logic [5:0]  minute_out,
  input logic [5:0]  second_out
);

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transfer");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(year_out) && $stable(month_out) &&
    $stable(day_of_month) && $stable(day_of_year) && $stable(hour_out) &&
    $stable(minute_out) && $stable(second_out))
    else $error("result fields changed while stalled");

  // The converter is busy right after taking an item.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // Every delivered date and time field lies within its legal calendar range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_out >= 4'd1) && (month_out <= 4'd12) &&
    (day_of_month >= 5'd1) && (day_of_year >= 9'd1) && (day_of_year <= 9'd366) &&
    ({4'd0, day_of_month} <= day_of_year) && (hour_out <= 5'd23) &&
    (minute_out <= 6'd59) && (second_out <= 6'd59))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_date etd_checker u_etd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (request.valid),
  .in_ready     (request.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .year_out     (result.year_out),
  .month_out    (result.month_out),
  .day_of_month (result.day_of_month),
  .day_of_year  (result.day_of_year),
  .hour_out     (result.hour_out),
  .minute_out   (result.minute_out),
  .second_out   (result.second_out)
);

// File: tb/epoch_seconds_to_date_tb.sv
// Self-checking testbench for the epoch-seconds-to-date converter.
module epoch_seconds_to_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etd_pkg::*;

  // Calendar fields of one converted timestamp, at the block's widths.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [8:0]  yday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  // An expected date together with the seconds count it came from.
  typedef struct {
    logic [31:0] secs;
    date_t       date;
  } date_entry_t;

  // Scoreboard: predicts the date of each accepted count and checks results in order.
  class date_scoreboard;
    date_entry_t pending_dates[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Gregorian leap rule.
    static function bit is_leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned year_length(int unsigned y);
      return (is_leap_year(y) ? 366 : 365) * SECS_PER_DAY;
    endfunction

    // Seconds from the base year to the first second of year y.
    static function longint unsigned year_start(int unsigned y);
      longint unsigned total;
      total = 0;
      for (int unsigned k = BASE_YEAR; k < y; k++) total += year_length(k);
      return total;
    endfunction

    // Walks whole years, splits the remainder, then walks the months.
    function date_t predict_date(logic [31:0] secs);
      date_t       d;
      int unsigned left;
      int unsigned year;
      int unsigned doy;
      int unsigned mday;
      int unsigned mon;
      int unsigned mdays[12];
      left = secs;
      year = BASE_YEAR;
      while (left >= year_length(year)) begin
        left -= year_length(year);
        year++;
      end
      doy = left / SECS_PER_DAY + 1;
      left = left % SECS_PER_DAY;
      d.hour = 5'(left / SECS_PER_HOUR);
      left = left % SECS_PER_HOUR;
      d.minute = 6'(left / 60);
      d.second = 6'(left % 60);
      mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (is_leap_year(year)) mdays[1] = 29;
      mon = 1;
      mday = doy;
      while (mon < 13 && mday > mdays[mon-1]) begin
        mday -= mdays[mon-1];
        mon++;
      end
      d.year = 12'(year);
      d.month = 4'(mon);
      d.mday = 5'(mday);
      d.yday = 9'(doy);
      return d;
    endfunction

    // Records an accepted seconds count.
    function void note_seconds(logic [31:0] secs);
      date_entry_t e;
      e.secs = secs;
      e.date = predict_date(secs);
      pending_dates.push_back(e);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compares one result with the oldest expectation, field by field.
    task check_date(date_t got);
      date_entry_t e;
      if (pending_dates.size() == 0) begin
        report($sformatf("result with no transfer pending: %p", got));
        return;
      end
      e = pending_dates.pop_front();
      if (got.year !== e.date.year)
        report($sformatf("secs %0d year_out %0d, expected %0d", e.secs, got.year, e.date.year));
      if (got.month !== e.date.month)
        report($sformatf("secs %0d month_out %0d, expected %0d", e.secs, got.month,
                         e.date.month));
      if (got.mday !== e.date.mday)
        report($sformatf("secs %0d day_of_month %0d, expected %0d", e.secs, got.mday,
                         e.date.mday));
      if (got.yday !== e.date.yday)
        report($sformatf("secs %0d day_of_year %0d, expected %0d", e.secs, got.yday,
                         e.date.yday));
      if (got.hour !== e.date.hour)
        report($sformatf("secs %0d hour_out %0d, expected %0d", e.secs, got.hour, e.date.hour));
      if (got.minute !== e.date.minute)
        report($sformatf("secs %0d minute_out %0d, expected %0d", e.secs, got.minute,
                         e.date.minute));
      if (got.second !== e.date.second)
        report($sformatf("secs %0d second_out %0d, expected %0d", e.secs, got.second,
                         e.date.second));
    endtask
  endclass

  logic clk;
  logic rst;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  date_scoreboard sb;

  etd_in_if  seconds_ch ();
  etd_out_if date_ch ();

  epoch_seconds_to_date dut (
    .clk     (clk),
    .rst     (rst),
    .request (seconds_ch),
    .result  (date_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    #4_000_000;
    $display("epoch_seconds_to_date regression: fail");
    $finish;
  end

  // Offers one seconds count, with random idle cycles before it, and waits for the transfer.
  task send_seconds(logic [31:0] secs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      seconds_ch.valid <= 1'b0;
      @(posedge clk);
    end
    seconds_ch.valid <= 1'b1;
    seconds_ch.epoch_seconds <= secs;
    do @(posedge clk); while (!(seconds_ch.valid && seconds_ch.ready));
    sb.note_seconds(secs);
  endtask

  // Random count, weighted toward year, month and day edges.
  function logic [31:0] pick_seconds();
    int unsigned y;
    longint unsigned base;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        y = $urandom_range(BASE_YEAR + 1, 2106);
        base = date_scoreboard::year_start(y);
        if ($urandom_range(0, 1) == 1) v = 32'(base + $urandom_range(0, 2 * SECS_PER_DAY));
        else v = 32'(base - 1 - $urandom_range(0, 2 * SECS_PER_DAY));
      end
      6: begin
        y = $urandom_range(BASE_YEAR, 2105);
        v = 32'(date_scoreboard::year_start(y) + 58 * SECS_PER_DAY
                + $urandom_range(0, 2 * SECS_PER_DAY));
      end
      7: v = 32'($urandom_range(0, 49709) * SECS_PER_DAY + SECS_PER_DAY - 1
                 - $urandom_range(0, 120));
      8: v = 32'hFFFF_FFFF - $urandom_range(0, 1_000_000);
      default: v = $urandom_range(0, 4000);
    endcase
    return v;
  endfunction

  // Result side: checks every transfer and stalls at random.
  initial begin
    date_t got;
    forever begin
      @(posedge clk);
      if (date_ch.valid && date_ch.ready) begin
        got.year = date_ch.year_out;
        got.month = date_ch.month_out;
        got.mday = date_ch.day_of_month;
        got.yday = date_ch.day_of_year;
        got.hour = date_ch.hour_out;
        got.minute = date_ch.minute_out;
        got.second = date_ch.second_out;
        sb.check_date(got);
      end
      date_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus: reset, directed edge cases, then four phases of random counts with different idling and stalling.
  initial begin
    logic [31:0] directed[$];
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst <= 1'b1;
    seconds_ch.valid <= 1'b0;
    seconds_ch.epoch_seconds <= '0;
    date_ch.ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, minute/hour/day rollovers, common and leap year boundaries,
    // leap days in 1972 and 2000, the skipped leap day of 2100, and the top of the range.
    directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                 32'(date_scoreboard::year_start(1971) - 1),
                 32'(date_scoreboard::year_start(1971)),
                 32'(date_scoreboard::year_start(1972) + 59 * SECS_PER_DAY),
                 32'(date_scoreboard::year_start(1973) - 1),
                 32'(date_scoreboard::year_start(1973)),
                 32'(date_scoreboard::year_start(2000) + 59 * SECS_PER_DAY),
                 32'(date_scoreboard::year_start(2001) - 1),
                 32'(date_scoreboard::year_start(2100) + 59 * SECS_PER_DAY - 1),
                 32'(date_scoreboard::year_start(2100) + 59 * SECS_PER_DAY),
                 32'(date_scoreboard::year_start(2106)),
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
    foreach (directed[i]) send_seconds(directed[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (195) send_seconds(pick_seconds());
    end
    seconds_ch.valid <= 1'b0;

    // Drain the remaining results, then allow one worst-case conversion more.
    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("epoch_seconds_to_date regression: pass");
    end else begin
      $display("epoch_seconds_to_date regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/etd_pkg.sv
design/etd_in_if.sv
design/etd_out_if.sv
design/etd_ctrl.sv
design/etd_dp.sv
design/epoch_seconds_to_date.sv
design/etd_checker.sv
tb/epoch_seconds_to_date_tb.sv
